@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on the rising edge, ignored while reset is high
`define CHK_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// check a property on the rising edge, including cycles in reset
`define CHK_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

@@ rtl/ctd_pkg.sv @@
// types, constants and helpers for the chunked transfer decoder
// no dependencies
package ctd_pkg;

  localparam int CNT_W = 31;
  localparam logic [CNT_W-1:0] CNT_MAX = 31'h7FFF_FFFF;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef enum logic [2:0] {
    PH_SIZE      = 3'd0,
    PH_DATA      = 3'd1,
    PH_DATA_END  = 3'd2,
    PH_TRL_START = 3'd3,
    PH_TRL_LINE  = 3'd4,
    PH_DONE      = 3'd5,
    PH_ERROR     = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_MORE = 2'd0,
    ST_DONE = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef struct packed {
    status_t          status;
    logic             payload_valid;
    logic [7:0]       payload_byte;
    logic [CNT_W-1:0] decoded_length;
    logic [CNT_W-1:0] raw_length;
  } result_t;

  // {is_hex, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

@@ rtl/ctd_core.sv @@
// parser state and per-byte next-state logic of the chunked transfer decoder
// depends on ctd_pkg
module ctd_core #(
  parameter int LENGTH_BITS = 31
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              start_of_body,
  output ctd_pkg::result_t  result
);
  import ctd_pkg::*;

  phase_t                 phase, phase_next, cur_phase;
  logic [LENGTH_BITS-1:0] chunk_remaining, chunk_remaining_next, cur_rem;
  logic                   hex_active, hex_active_next, cur_hex;
  logic                   pending_cr, pending_cr_next, cur_pcr;
  logic [CNT_W-1:0]       decoded_count, decoded_count_next, cur_dec;
  logic [CNT_W-1:0]       raw_count, raw_count_next, cur_raw;
  logic [4:0]             digit;
  logic                   pv;

  assign digit = hex_digit(data_byte);

  always_comb begin
    cur_phase = start_of_body ? PH_SIZE : phase;
    cur_rem   = start_of_body ? '0 : chunk_remaining;
    cur_hex   = start_of_body ? 1'b1 : hex_active;
    cur_pcr   = start_of_body ? 1'b0 : pending_cr;
    cur_dec   = start_of_body ? '0 : decoded_count;
    cur_raw   = start_of_body ? '0 : raw_count;

    phase_next           = cur_phase;
    chunk_remaining_next = cur_rem;
    hex_active_next      = cur_hex;
    pending_cr_next      = cur_pcr;
    decoded_count_next   = cur_dec;
    raw_count_next       = cur_raw;
    pv                   = 1'b0;

    if (cur_phase != PH_DONE && cur_phase != PH_ERROR) begin
      if (cur_raw != CNT_MAX) begin
        raw_count_next = cur_raw + CNT_W'(1);
      end
      unique case (cur_phase)
        PH_SIZE: begin
          pending_cr_next = 1'b0;
          if (data_byte == CH_LF) begin
            phase_next = (cur_rem == '0) ? PH_TRL_START : PH_DATA;
          end else if (data_byte == CH_CR) begin
            pending_cr_next = 1'b1;
            hex_active_next = 1'b0;
          end else if (cur_hex) begin
            if (!digit[4]) begin
              hex_active_next = 1'b0;
            end else if (cur_rem[LENGTH_BITS-1 -: 4] != 4'd0) begin
              phase_next = PH_ERROR;
            end else begin
              chunk_remaining_next = {cur_rem[LENGTH_BITS-5:0], digit[3:0]};
            end
          end
        end
        PH_DATA: begin
          pv = 1'b1;
          if (cur_dec != CNT_MAX) begin
            decoded_count_next = cur_dec + CNT_W'(1);
          end
          chunk_remaining_next = cur_rem - LENGTH_BITS'(1);
          if (cur_rem == LENGTH_BITS'(1)) begin
            phase_next      = PH_DATA_END;
            pending_cr_next = 1'b0;
          end
        end
        PH_DATA_END: begin
          if (data_byte == CH_LF) begin
            phase_next           = PH_SIZE;
            chunk_remaining_next = '0;
            hex_active_next      = 1'b1;
            pending_cr_next      = 1'b0;
          end else if (data_byte == CH_CR && !cur_pcr) begin
            pending_cr_next = 1'b1;
          end else begin
            phase_next = PH_ERROR;
          end
        end
        PH_TRL_START: begin
          if (data_byte == CH_LF) begin
            phase_next      = PH_DONE;
            pending_cr_next = 1'b0;
          end else if (data_byte == CH_CR) begin
            pending_cr_next = 1'b1;
            if (cur_pcr) begin
              phase_next = PH_TRL_LINE;
            end
          end else begin
            phase_next      = PH_TRL_LINE;
            pending_cr_next = 1'b0;
          end
        end
        PH_TRL_LINE: begin
          if (data_byte == CH_LF) begin
            phase_next      = PH_TRL_START;
            pending_cr_next = 1'b0;
          end else begin
            pending_cr_next = (data_byte == CH_CR);
          end
        end
        default: begin
          phase_next = PH_ERROR;
        end
      endcase
    end

    result.status = (phase_next == PH_DONE)  ? ST_DONE :
                    (phase_next == PH_ERROR) ? ST_BAD  : ST_MORE;
    result.payload_valid  = pv;
    result.payload_byte   = pv ? data_byte : 8'd0;
    result.decoded_length = decoded_count_next;
    result.raw_length     = raw_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SIZE;
      chunk_remaining <= '0;
      hex_active      <= 1'b1;
      pending_cr      <= 1'b0;
      decoded_count   <= '0;
      raw_count       <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      chunk_remaining <= chunk_remaining_next;
      hex_active      <= hex_active_next;
      pending_cr      <= pending_cr_next;
      decoded_count   <= decoded_count_next;
      raw_count       <= raw_count_next;
    end
  end

endmodule

@@ rtl/ctd_skid.sv @@
// two-entry result buffer: output register plus skid register
// depends on ctd_pkg
module ctd_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  input  ctd_pkg::result_t up_data,
  output logic             up_stall,
  output logic             down_valid,
  output ctd_pkg::result_t down_data,
  input  logic             down_stall
);
  import ctd_pkg::*;

  logic    out_full, skid_full;
  result_t out_reg, skid_reg;
  logic    take;

  assign up_stall   = skid_full;
  assign take       = up_valid && !skid_full;
  assign down_valid = out_full;
  assign down_data  = out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full  <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_full || !down_stall) begin
      if (skid_full) begin
        out_full  <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_full <= take;
      end
    end else if (take) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_full || !down_stall) begin
      out_reg <= skid_full ? skid_reg : up_data;
    end else if (take) begin
      skid_reg <= up_data;
    end
  end

endmodule

@@ rtl/chunked_transfer_decoder.sv @@
// top level of the chunked transfer decoder
// depends on ctd_pkg, ctd_core, ctd_skid
// Decodes an HTTP chunked body presented one byte per item and returns one
// result per byte: status (needs more, complete, malformed), the payload byte
// when the byte is chunk data, and saturating decoded and raw byte counts.
// Raise start_of_body with the first byte of each body. The block takes one
// item every cycle while in_stall is low, and its result is registered. All
// per-byte parsing is a single pass of logic ahead of the output registers,
// and a two-entry output buffer keeps input flowing while the result side
// stalls; input stalls only when both entries wait.
// LENGTH_BITS sets the largest chunk size accepted, 2^LENGTH_BITS - 1.
module chunked_transfer_decoder #(
  parameter int LENGTH_BITS = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        start_of_body,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        payload_valid,
  output logic [7:0]  payload_byte,
  output logic [30:0] decoded_length,
  output logic [30:0] raw_length
);
  import ctd_pkg::*;

  result_t step_res, out_res;
  logic    accept;

  assign accept = in_valid && !in_stall;

  ctd_core #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (data_byte),
    .start_of_body(start_of_body),
    .result       (step_res)
  );

  ctd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .up_valid  (in_valid),
    .up_data   (step_res),
    .up_stall  (in_stall),
    .down_valid(out_valid),
    .down_data (out_res),
    .down_stall(out_stall)
  );

  assign status         = out_res.status;
  assign payload_valid  = out_res.payload_valid;
  assign payload_byte   = out_res.payload_byte;
  assign decoded_length = out_res.decoded_length;
  assign raw_length     = out_res.raw_length;

endmodule

@@ rtl/ctd_checker.sv @@
// port-level checks for the chunked transfer decoder, bound to the top level
// depends on ctd_pkg, assert_macros.svh, chunked_transfer_decoder
`include "assert_macros.svh"

module ctd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  data_byte,
  input logic        start_of_body,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic        payload_valid,
  input logic [7:0]  payload_byte,
  input logic [30:0] decoded_length,
  input logic [30:0] raw_length
);
  import ctd_pkg::*;

  `CHK_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(raw_length))
  `CHK_ASSERT(a_no_stray_byte, clk, rst, out_valid && !payload_valid |-> payload_byte == 8'd0)
  `CHK_ASSERT(a_payload_open, clk, rst, out_valid && payload_valid |-> status == ST_MORE)
  `CHK_ASSERT(a_count_order, clk, rst, out_valid |-> decoded_length <= raw_length)
  `CHK_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

endmodule

bind chunked_transfer_decoder ctd_checker u_ctd_checker (.*);

@@ sim/tb_chunked_transfer_decoder.sv @@
// self-checking testbench for chunked_transfer_decoder
// a directed table, then random chunked bodies under several idle and stall mixes,
// every result checked against the table or a byte-level decoder model; needs ctd_pkg and the rtl
module tb_chunked_transfer_decoder;
  timeunit 1ns;
  timeprecision 1ps;
  import ctd_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [7:0] b;
    logic       sob;
    logic       typed;
    result_t    want;
  } stim_row_t;

  localparam longint unsigned SIZE_LIMIT = (64'd1 << 31) - 1;
  localparam int STUCK_LIMIT = 2000;
  localparam int PHASE_ITEMS = 300;
  localparam result_t NO_WANT = '0;
  localparam int N_DIR = 26;
  localparam stim_row_t DIR_ROWS [N_DIR] = '{
    '{"0",    1'b1, 1'b1, '{ST_MORE, 1'b0, 8'h00, 31'd0, 31'd1}},
    '{CH_LF,  1'b0, 1'b0, NO_WANT},
    '{CH_LF,  1'b0, 1'b1, '{ST_DONE, 1'b0, 8'h00, 31'd0, 31'd3}},
    '{8'hFF,  1'b0, 1'b1, '{ST_DONE, 1'b0, 8'h00, 31'd0, 31'd3}},
    // size overflow on the eighth digit
    '{"F",    1'b1, 1'b0, NO_WANT},
    '{"f",    1'b0, 1'b0, NO_WANT},
    '{"F",    1'b0, 1'b0, NO_WANT},
    '{"f",    1'b0, 1'b0, NO_WANT},
    '{"F",    1'b0, 1'b0, NO_WANT},
    '{"f",    1'b0, 1'b0, NO_WANT},
    '{"F",    1'b0, 1'b0, NO_WANT},
    '{"F",    1'b0, 1'b1, '{ST_BAD, 1'b0, 8'h00, 31'd0, 31'd8}},
    // extension, payload extremes, bad data terminator
    '{"2",    1'b1, 1'b0, NO_WANT},
    '{";",    1'b0, 1'b0, NO_WANT},
    '{CH_CR,  1'b0, 1'b0, NO_WANT},
    '{CH_LF,  1'b0, 1'b0, NO_WANT},
    '{8'h00,  1'b0, 1'b1, '{ST_MORE, 1'b1, 8'h00, 31'd1, 31'd5}},
    '{8'hFF,  1'b0, 1'b1, '{ST_MORE, 1'b1, 8'hFF, 31'd2, 31'd6}},
    '{CH_CR,  1'b0, 1'b0, NO_WANT},
    '{"x",    1'b0, 1'b1, '{ST_BAD, 1'b0, 8'h00, 31'd2, 31'd8}},
    // lone cr as size line content, no digits, one trailer line
    '{CH_CR,  1'b1, 1'b0, NO_WANT},
    '{"q",    1'b0, 1'b0, NO_WANT},
    '{CH_LF,  1'b0, 1'b0, NO_WANT},
    '{"X",    1'b0, 1'b0, NO_WANT},
    '{CH_LF,  1'b0, 1'b0, NO_WANT},
    '{CH_LF,  1'b0, 1'b1, '{ST_DONE, 1'b0, 8'h00, 31'd0, 31'd6}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        start_of_body = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [30:0] decoded_length;
  logic [30:0] raw_length;

  logic        row_typed = 1'b0;
  result_t     row_want = '0;

  idle_mode_t  mode = IDLE_NONE;
  result_t     expected_q[$];
  logic [8:0]  body_q[$];
  int unsigned n_live = 0;
  int unsigned n_in = 0;
  int unsigned n_out = 0;
  int unsigned n_done = 0;
  int unsigned n_malformed = 0;
  int unsigned n_bad = 0;
  int unsigned stuck = 0;

  // decoder model state
  phase_t      ph = PH_SIZE;
  logic [30:0] rem = '0;
  bit          hex_on = 1'b1;
  bit          cr_wait = 1'b0;
  logic [30:0] dec_cnt = '0;
  logic [30:0] raw_cnt = '0;

  chunked_transfer_decoder DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .start_of_body(start_of_body),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .payload_valid(payload_valid),
    .payload_byte(payload_byte),
    .decoded_length(decoded_length),
    .raw_length(raw_length)
  );

  always #5 clk = ~clk;

  function automatic void start_line();
    ph = PH_SIZE;
    rem = '0;
    hex_on = 1'b1;
    cr_wait = 1'b0;
  endfunction

  function automatic void close_size_line();
    cr_wait = 1'b0;
    ph = (rem == '0) ? PH_TRL_START : PH_DATA;
  endfunction

  function automatic void trailer_byte(logic [7:0] b);
    if (b == CH_CR) begin
      cr_wait = 1'b1;
    end else if (b == CH_LF) begin
      ph = PH_TRL_START;
      cr_wait = 1'b0;
    end
  endfunction

  function automatic result_t decode_byte(logic [7:0] b, logic sob);
    result_t r;
    int d;
    bit is_data;
    is_data = 1'b0;
    if (sob) begin
      start_line();
      dec_cnt = '0;
      raw_cnt = '0;
    end
    if (ph != PH_DONE && ph != PH_ERROR) begin
      if (raw_cnt != CNT_MAX) raw_cnt++;
      case (ph)
        PH_SIZE: begin
          if (cr_wait && b == CH_LF) begin
            close_size_line();
          end else begin
            cr_wait = 1'b0;
            if (b == CH_CR) begin
              cr_wait = 1'b1;
              hex_on = 1'b0;
            end else if (b == CH_LF) begin
              close_size_line();
            end else if (hex_on) begin
              if (b >= "0" && b <= "9") d = b - "0";
              else if (b >= "a" && b <= "f") d = b - "a" + 10;
              else if (b >= "A" && b <= "F") d = b - "A" + 10;
              else d = -1;
              if (d < 0) hex_on = 1'b0;
              else if (longint'(rem) > (SIZE_LIMIT - longint'(d)) / 16) ph = PH_ERROR;
              else rem = (rem << 4) | 31'(d);
            end
          end
        end
        PH_DATA: begin
          is_data = 1'b1;
          if (dec_cnt != CNT_MAX) dec_cnt++;
          rem--;
          if (rem == '0) begin
            ph = PH_DATA_END;
            cr_wait = 1'b0;
          end
        end
        PH_DATA_END: begin
          if (cr_wait) begin
            if (b == CH_LF) start_line();
            else ph = PH_ERROR;
          end else if (b == CH_CR) begin
            cr_wait = 1'b1;
          end else if (b == CH_LF) begin
            start_line();
          end else begin
            ph = PH_ERROR;
          end
        end
        PH_TRL_START: begin
          if (cr_wait) begin
            cr_wait = 1'b0;
            if (b == CH_LF) begin
              ph = PH_DONE;
            end else begin
              ph = PH_TRL_LINE;
              trailer_byte(b);
            end
          end else if (b == CH_CR) begin
            cr_wait = 1'b1;
          end else if (b == CH_LF) begin
            ph = PH_DONE;
          end else begin
            ph = PH_TRL_LINE;
          end
        end
        PH_TRL_LINE: begin
          if (cr_wait && b == CH_LF) begin
            cr_wait = 1'b0;
            ph = PH_TRL_START;
          end else begin
            cr_wait = 1'b0;
            trailer_byte(b);
          end
        end
        default: ph = PH_ERROR;
      endcase
    end
    r.status = (ph == PH_DONE) ? ST_DONE : ((ph == PH_ERROR) ? ST_BAD : ST_MORE);
    r.payload_valid = is_data;
    r.payload_byte = is_data ? b : 8'h00;
    r.decoded_length = dec_cnt;
    r.raw_length = raw_cnt;
    return r;
  endfunction

  task automatic report(string what);
    $display("ERROR: %s", what);
    n_bad++;
  endtask

  function automatic int gap_pct(bit recv_side);
    case (mode)
      IDLE_SEND: return recv_side ? 0 : 87;
      IDLE_RECV: return recv_side ? 87 : 0;
      IDLE_BOTH: return 23;
      default:   return 0;
    endcase
  endfunction

  function automatic void push_b(logic [7:0] b);
    body_q.push_back({1'b0, b});
  endfunction

  function automatic void add_eol();
    if ($urandom_range(1, 0) == 1) push_b(CH_CR);
    push_b(CH_LF);
  endfunction

  function automatic logic [7:0] hex_char(int unsigned v);
    if (v < 10) return 8'("0" + v);
    return ($urandom_range(1, 0) == 1) ? 8'("a" + v - 10) : 8'("A" + v - 10);
  endfunction

  function automatic void add_size(int unsigned sz);
    int nib;
    if (!(sz == 0 && $urandom_range(4, 0) == 0)) begin
      repeat (($urandom_range(3, 0) == 0) ? $urandom_range(2, 1) : 0) push_b("0");
      nib = 7;
      while (nib > 0 && ((sz >> (4 * nib)) & 15) == 0) nib--;
      for (int k = nib; k >= 0; k--) push_b(hex_char((sz >> (4 * k)) & 15));
    end
    if ($urandom_range(3, 0) == 0) begin
      push_b(";");
      repeat ($urandom_range(5, 0)) push_b(8'($urandom_range(126, 32)));
      if ($urandom_range(2, 0) == 0) begin
        push_b(CH_CR);
        push_b(8'($urandom_range(126, 32)));
      end
    end
    add_eol();
  endfunction

  function automatic void make_body();
    int unsigned roll, sz, n, idx;
    body_q.delete();
    roll = $urandom_range(99, 0);
    if (roll < 4) begin
      // raw noise, start flag anywhere
      repeat ($urandom_range(12, 1))
        body_q.push_back({($urandom_range(7, 0) == 0), 8'($urandom_range(255, 0))});
      return;
    end
    if (roll < 8) begin
      // huge or overflowing size
      repeat ($urandom_range(10, 8)) push_b(hex_char($urandom_range(15, 1)));
      add_eol();
      repeat ($urandom_range(6, 0)) push_b(8'($urandom_range(255, 0)));
    end else begin
      repeat ($urandom_range(3, 0)) begin
        sz = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
        add_size(sz);
        repeat (sz) push_b(8'($urandom_range(255, 0)));
        add_eol();
      end
      add_size(0);
      repeat ($urandom_range(2, 0)) begin
        if ($urandom_range(5, 0) == 0) begin
          push_b(CH_CR);
          push_b(8'($urandom_range(126, 32)));
        end
        repeat ($urandom_range(6, 1)) push_b(8'($urandom_range(126, 32)));
        add_eol();
      end
      add_eol();
      if (roll < 20) begin
        idx = $urandom_range(body_q.size() - 1, 0);
        body_q[idx] = {1'b0, 8'($urandom_range(255, 0))};
      end else if (roll < 28) begin
        n = $urandom_range(body_q.size() - 1, 1);
        while (body_q.size() > n) void'(body_q.pop_back());
      end
    end
    if ($urandom_range(4, 0) == 0)
      repeat ($urandom_range(3, 1)) push_b(8'($urandom_range(255, 0)));
    body_q[0][8] = 1'b1;
  endfunction

  task automatic send_item(logic [7:0] b, logic sob, logic typed, result_t want);
    while ($urandom_range(99, 0) < gap_pct(1'b0)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    start_of_body <= sob;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (in_stall);
  endtask

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99, 0) < gap_pct(1'b1));
  end

  always @(posedge clk) begin : monitor
    result_t want;
    bit acc_in, acc_out;
    acc_in = !rst && in_valid && !in_stall;
    acc_out = !rst && out_valid && !out_stall;
    if (acc_in) begin
      if (start_of_body || (ph != PH_DONE && ph != PH_ERROR)) n_live++;
      want = decode_byte(data_byte, start_of_body);
      if (row_typed) want = row_want;
      expected_q.push_back(want);
      n_in++;
    end
    if (acc_out) begin
      n_out++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", n_out));
      end else begin
        want = expected_q.pop_front();
        if (want.status == ST_DONE) n_done++;
        if (want.status == ST_BAD) n_malformed++;
        if (status !== want.status)
          report($sformatf("result %0d status %0d, expected %0d", n_out, status, want.status));
        if (payload_valid !== want.payload_valid)
          report($sformatf("result %0d payload_valid %0b, expected %0b", n_out,
                           payload_valid, want.payload_valid));
        if (payload_byte !== want.payload_byte)
          report($sformatf("result %0d payload_byte %02h, expected %02h", n_out,
                           payload_byte, want.payload_byte));
        if (decoded_length !== want.decoded_length)
          report($sformatf("result %0d decoded_length %0d, expected %0d", n_out,
                           decoded_length, want.decoded_length));
        if (raw_length !== want.raw_length)
          report($sformatf("result %0d raw_length %0d, expected %0d", n_out,
                           raw_length, want.raw_length));
      end
    end
    if (rst || acc_in || acc_out) stuck = 0;
    else stuck++;
  end

  initial begin : watchdog
    do @(posedge clk); while (stuck < STUCK_LIMIT);
    $display("timeout: nothing moved for %0d cycles", STUCK_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned goal;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int k = 0; k < N_DIR; k++)
      send_item(DIR_ROWS[k].b, DIR_ROWS[k].sob, DIR_ROWS[k].typed, DIR_ROWS[k].want);
    for (int k = 0; k < 4; k++) begin
      mode = idle_mode_t'(k);
      if (mode == IDLE_RECV) begin
        // hold off until the decoder has drained
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_q.size() != 0);
      end
      goal = n_live + PHASE_ITEMS;
      while (n_live < goal) begin
        make_body();
        foreach (body_q[i]) send_item(body_q[i][7:0], body_q[i][8], 1'b0, NO_WANT);
      end
    end
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_q.size() != 0);
    repeat (20) @(posedge clk);
    if (expected_q.size() != 0)
      report($sformatf("%0d results never arrived", expected_q.size()));
    $display("%0d bytes sent across four idle/stall mixes, %0d results checked", n_in, n_out);
    $display("results reporting a complete body: %0d, malformed: %0d", n_done, n_malformed);
    if (n_bad == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/ctd_pkg.sv
rtl/ctd_core.sv
rtl/ctd_skid.sv
rtl/chunked_transfer_decoder.sv
rtl/ctd_checker.sv
sim/tb_chunked_transfer_decoder.sv
